// ===== sv/pps_pkg.sv =====
// pps_pkg: shared types, constants and tables for the pure pursuit steering block
// no dependencies; imported by every module of the block
package pps_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int ANGLE_WIDTH    = 16;
  localparam int INDEX_WIDTH    = 10;
  localparam int TABLE_DEPTH_DEF = 1024;

  // derived internal widths
  localparam int YQW = ANGLE_WIDTH + 3;      // yaw in Q16
  localparam int XRW = POSITION_WIDTH + 2;   // rear axle point
  localparam int EW  = POSITION_WIDTH + 3;   // waypoint minus rear axle
  localparam int VW  = POSITION_WIDTH + 5;   // cordic x/y datapath
  localparam int ZW  = 22;                   // cordic angle datapath, Q16
  localparam int ITERS = 16;
  localparam int IT_W  = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = 2;
  localparam int QCW = 3;

  localparam logic signed [ZW-1:0] PI_Q16      = 22'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [ZW-1:0] TWO_PI_Q16  = 22'sd411775;
  localparam logic signed [VW-1:0] CORDIC_K_Q30 = 37'sd652032875;
  localparam logic signed [14:0]   STEER_MAX   = 15'sd12868;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_POSE = 1'b1
  } pps_cmd_t;

  typedef enum logic [1:0] {
    CFG_LOOKAHEAD = 2'd0,
    CFG_WHEELBASE = 2'd1,
    CFG_SPEED     = 2'd2,
    CFG_COUNT     = 2'd3
  } pps_cfg_idx_t;

  typedef struct packed {
    logic                             cmd;
    logic [INDEX_WIDTH-1:0]           waypoint_index;
    logic signed [POSITION_WIDTH-1:0] pos_x;
    logic signed [POSITION_WIDTH-1:0] pos_y;
    logic signed [ANGLE_WIDTH-1:0]    yaw;
    logic [INDEX_WIDTH-1:0]           closest_index;
  } pps_in_t;

  typedef struct packed {
    logic signed [14:0]     steer_cmd;
    logic signed [15:0]     speed_cmd;
    logic [INDEX_WIDTH-1:0] lookahead_index;
  } pps_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                             is_pose;
    logic [INDEX_WIDTH-1:0]           waddr;
    logic signed [POSITION_WIDTH-1:0] pos_x;
    logic signed [POSITION_WIDTH-1:0] pos_y;
    logic signed [YQW-1:0]            yaw_q16;
    logic [INDEX_WIDTH-1:0]           start_idx;
  } pps_item_t;

  typedef struct packed {
    logic start;
    logic vec;
  } pps_cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pps_cordic_sts_t;

  // arctangent table, Q16 radians
  function automatic logic signed [ZW-1:0] atan_q16(input logic [IT_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:    r = 22'sd51472;
      4'd1:    r = 22'sd30386;
      4'd2:    r = 22'sd16055;
      4'd3:    r = 22'sd8150;
      4'd4:    r = 22'sd4091;
      4'd5:    r = 22'sd2047;
      4'd6:    r = 22'sd1024;
      4'd7:    r = 22'sd512;
      4'd8:    r = 22'sd256;
      4'd9:    r = 22'sd128;
      4'd10:   r = 22'sd64;
      4'd11:   r = 22'sd32;
      4'd12:   r = 22'sd16;
      4'd13:   r = 22'sd8;
      4'd14:   r = 22'sd4;
      4'd15:   r = 22'sd2;
      default: r = 22'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/pps_front.sv =====
// pps_front: accepts input beats, classifies them and queues them for the back end
// depends on pps_pkg
module pps_front
  import pps_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pps_in_t         in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output pps_item_t       q_data,
  output logic [QCW-1:0]  q_count
);

  pps_item_t        q_mem_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  pps_item_t        item;
  logic             push, pop;

  // classify: load or pose, start index clamped at zero, yaw to Q16
  always_comb begin
    item.is_pose   = (in_data.cmd == CMD_POSE);
    item.waddr     = in_data.waypoint_index;
    item.pos_x     = in_data.pos_x;
    item.pos_y     = in_data.pos_y;
    item.yaw_q16   = $signed({in_data.yaw, 3'b000});
    item.start_idx = (in_data.closest_index != '0) ?
                     in_data.closest_index - INDEX_WIDTH'(1) : '0;
  end

  assign in_ready = (cnt_r != QCW'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_data   = q_mem_r[rd_ptr_r];
  assign q_count  = cnt_r;

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPW'(1);
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item;
  end

endmodule

// ===== sv/pps_cordic.sv =====
// pps_cordic: shared iterative cordic, rotation and vectoring, one iteration a cycle
// depends on pps_pkg
module pps_cordic
  import pps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pps_cordic_req_t       req,
  input  logic signed [VW-1:0]  x0,
  input  logic signed [VW-1:0]  y0,
  input  logic signed [ZW-1:0]  z0,
  output pps_cordic_sts_t       sts,
  output logic signed [VW-1:0]  x_out,
  output logic signed [VW-1:0]  y_out,
  output logic signed [ZW-1:0]  z_out
);

  logic signed [VW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r;
  logic [IT_W-1:0]      it_r;
  logic                 run_r, done_r, vec_r, zero_r, neg_dir;

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign neg_dir = vec_r ? !y_r[VW-1] : z_r[ZW-1];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        it_r  <= '0;
      end else if (run_r) begin
        it_r <= it_r + IT_W'(1);
        if (it_r == IT_W'(ITERS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: preload with left half-plane fold for vectoring, then iterate
  always_ff @(posedge clk) begin
    if (req.start) begin
      vec_r <= req.vec;
      if (req.vec) begin
        zero_r <= (x0 == '0) && (y0 == '0);
        if (x0[VW-1]) begin
          x_r <= -x0;
          y_r <= -y0;
          z_r <= y0[VW-1] ? -PI_Q16 : PI_Q16;
        end else begin
          x_r <= x0;
          y_r <= y0;
          z_r <= '0;
        end
      end else begin
        zero_r <= 1'b0;
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
      end
    end else if (run_r) begin
      if (neg_dir) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_q16(it_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_q16(it_r);
      end
    end
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = zero_r ? '0 : z_r;

endmodule

// ===== sv/pps_back.sv =====
// pps_back: waypoint tables, lookahead scan and steering sequencer with output register
// depends on pps_pkg; drives the shared pps_cordic unit
module pps_back
  import pps_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  pps_item_t             q_data,
  input  logic [30:0]           lookahead,
  input  logic [30:0]           wheelbase,
  input  logic signed [15:0]    speed,
  input  logic [10:0]           wp_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pps_out_t              out_data,
  output pps_cordic_req_t       creq,
  output logic signed [VW-1:0]  c_x0,
  output logic signed [VW-1:0]  c_y0,
  output logic signed [ZW-1:0]  c_z0,
  input  pps_cordic_sts_t       csts,
  input  logic signed [VW-1:0]  c_x,
  input  logic signed [VW-1:0]  c_y,
  input  logic signed [ZW-1:0]  c_z
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = ($clog2(TABLE_DEPTH + 1) > 11) ? $clog2(TABLE_DEPTH + 1) : 11;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_ROT, S_MUL, S_AXLE, S_SCAN, S_VEC1, S_NUM, S_VEC2, S_OUT
  } state_t;

  state_t state_r;

  logic signed [POSITION_WIDTH-1:0] x_mem [TABLE_DEPTH];
  logic signed [POSITION_WIDTH-1:0] y_mem [TABLE_DEPTH];
  logic signed [POSITION_WIDTH-1:0] rd_x_r, rd_y_r;

  pps_item_t             item_r;
  logic                  pass_r, neg_r;
  logic signed [ZW-1:0]  ang_r;
  logic signed [31:0]    s_r, c_r;
  logic signed [63:0]    prod_c_r, prod_s_r;
  logic [61:0]           la2_r;
  logic signed [XRW-1:0] xr_r, yr_r;
  logic [NW-1:0]         scan_idx_r, last_r;
  logic                  issue_done_r;
  logic                  v1_r, v2_r, v3_r;
  logic [NW-1:0]         idx1_r, idx2_r, idx3_r, idx_r;
  logic signed [EW-1:0]  ex2_r, ey2_r, ex3_r, ey3_r;
  logic [30:0]           ax2_r, ay2_r;
  logic                  sat2_r, sat3_r;
  logic [61:0]           sqx_r, sqy_r;
  logic signed [14:0]    steer_r;
  logic                  out_valid_r;
  pps_out_t              out_data_r;
  pps_cordic_req_t       creq_r;
  logic signed [VW-1:0]  c_x0_r, c_y0_r;
  logic signed [ZW-1:0]  c_z0_r;

  logic [NW-1:0]         wa_ext, cnt_ext, count_eff, first;
  logic                  mem_we, issue_en, hit;
  logic signed [EW-1:0]  ex, ey, ax, ay;
  logic signed [ZW-1:0]  a1, a2, zr, st_full;
  logic                  fold_neg;
  logic signed [31:0]    s_sel, c_sel;
  logic signed [34:0]    num;

  assign q_ready = (state_r == S_IDLE);

  // table write on a load beat inside the table
  assign wa_ext = NW'(q_data.waddr);
  assign mem_we = (state_r == S_IDLE) && q_valid && !q_data.is_pose &&
                  (wa_ext < NW'(TABLE_DEPTH));

  assign cnt_ext   = NW'(wp_count);
  assign count_eff = (cnt_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : cnt_ext;
  assign first     = NW'(item_r.start_idx);
  assign issue_en  = (state_r == S_SCAN) && !issue_done_r;

  // waypoint tables, one read port for the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[wa_ext[AW-1:0]] <= q_data.pos_x;
      y_mem[wa_ext[AW-1:0]] <= q_data.pos_y;
    end
    rd_x_r <= x_mem[scan_idx_r[AW-1:0]];
    rd_y_r <= y_mem[scan_idx_r[AW-1:0]];
  end

  // scan stage two: offsets from the rear axle and saturation check
  assign ex = EW'(rd_x_r) - EW'(xr_r);
  assign ey = EW'(rd_y_r) - EW'(yr_r);
  assign ax = ex[EW-1] ? -ex : ex;
  assign ay = ey[EW-1] ? -ey : ey;

  // scan stage four: first waypoint beyond the lookahead circle, or the last one
  assign hit = v3_r && (sat3_r || ({1'b0, sqx_r} + {1'b0, sqy_r} > {1'b0, la2_r}) ||
               (idx3_r == last_r));

  // scan datapath pipeline
  always_ff @(posedge clk) begin
    idx1_r <= scan_idx_r;
    ex2_r  <= ex;
    ey2_r  <= ey;
    ax2_r  <= ax[30:0];
    ay2_r  <= ay[30:0];
    sat2_r <= (ax[EW-1:31] != '0) || (ay[EW-1:31] != '0);
    idx2_r <= idx1_r;
    sqx_r  <= 62'(ax2_r * ax2_r);
    sqy_r  <= 62'(ay2_r * ay2_r);
    ex3_r  <= ex2_r;
    ey3_r  <= ey2_r;
    sat3_r <= sat2_r;
    idx3_r <= idx2_r;
  end

  // angle wrap into plus/minus pi, then fold into plus/minus half pi
  always_comb begin
    if (ang_r > PI_Q16)       a1 = ang_r - TWO_PI_Q16;
    else if (ang_r < -PI_Q16) a1 = ang_r + TWO_PI_Q16;
    else                      a1 = ang_r;
    fold_neg = 1'b1;
    if (a1 > HALF_PI_Q16)       a2 = a1 - PI_Q16;
    else if (a1 < -HALF_PI_Q16) a2 = a1 + PI_Q16;
    else begin
      a2 = a1;
      fold_neg = 1'b0;
    end
  end

  assign s_sel = neg_r ? 32'(-c_y) : 32'(c_y);
  assign c_sel = neg_r ? 32'(-c_x) : 32'(c_x);
  assign num   = $signed(prod_s_r[63:29]);

  // steer rounding half up to Q13 and saturation
  assign zr      = c_z + ZW'(4);
  assign st_full = zr >>> 3;
  always_comb begin
    if (st_full > ZW'(STEER_MAX))       steer_r = STEER_MAX;
    else if (st_full < -ZW'(STEER_MAX)) steer_r = -STEER_MAX;
    else                                steer_r = 15'(st_full);
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      creq_r       <= '0;
      out_valid_r  <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      creq_r.start <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      v1_r <= issue_en;
      v2_r <= v1_r && (state_r == S_SCAN);
      v3_r <= v2_r && (state_r == S_SCAN);
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_data.is_pose) begin
            item_r  <= q_data;
            ang_r   <= ZW'(q_data.yaw_q16);
            pass_r  <= 1'b0;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (ang_r >= TWO_PI_Q16) begin
            ang_r <= ang_r - TWO_PI_Q16;
          end else if (ang_r <= -TWO_PI_Q16) begin
            ang_r <= ang_r + TWO_PI_Q16;
          end else begin
            neg_r  <= fold_neg;
            c_x0_r <= CORDIC_K_Q30;
            c_y0_r <= '0;
            c_z0_r <= a2;
            creq_r <= '{start: 1'b1, vec: 1'b0};
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (csts.done) begin
            s_r     <= s_sel;
            c_r     <= c_sel;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_c_r <= c_r * $signed({1'b0, wheelbase});
          prod_s_r <= s_r * $signed({1'b0, wheelbase});
          la2_r    <= 62'(lookahead * lookahead);
          state_r  <= pass_r ? S_NUM : S_AXLE;
        end
        S_AXLE: begin
          xr_r <= XRW'(item_r.pos_x) - XRW'($signed(prod_c_r[63:31]));
          yr_r <= XRW'(item_r.pos_y) - XRW'($signed(prod_s_r[63:31]));
          if (first >= count_eff) begin
            idx_r   <= '0;
            c_x0_r  <= '0;
            c_y0_r  <= '0;
            creq_r  <= '{start: 1'b1, vec: 1'b1};
            state_r <= S_VEC1;
          end else begin
            scan_idx_r   <= first;
            last_r       <= count_eff - NW'(1);
            issue_done_r <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_en) begin
            scan_idx_r <= scan_idx_r + NW'(1);
            if (scan_idx_r == last_r) issue_done_r <= 1'b1;
          end
          if (hit) begin
            idx_r   <= idx3_r;
            c_x0_r  <= VW'(ex3_r);
            c_y0_r  <= VW'(ey3_r);
            creq_r  <= '{start: 1'b1, vec: 1'b1};
            v1_r    <= 1'b0;
            v2_r    <= 1'b0;
            v3_r    <= 1'b0;
            state_r <= S_VEC1;
          end
        end
        S_VEC1: begin
          if (csts.done) begin
            ang_r   <= c_z - ZW'(item_r.yaw_q16);
            pass_r  <= 1'b1;
            state_r <= S_RED;
          end
        end
        S_NUM: begin
          c_x0_r  <= VW'({1'b0, lookahead});
          c_y0_r  <= VW'(num);
          creq_r  <= '{start: 1'b1, vec: 1'b1};
          state_r <= S_VEC2;
        end
        S_VEC2: begin
          if (csts.done) begin
            state_r <= S_OUT;
          end
        end
        // cordic stays idle here, so its angle still holds the steering result
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.steer_cmd       <= steer_r;
            out_data_r.speed_cmd       <= speed;
            out_data_r.lookahead_index <= idx_r[INDEX_WIDTH-1:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign creq      = creq_r;
  assign c_x0      = c_x0_r;
  assign c_y0      = c_y0_r;
  assign c_z0      = c_z0_r;

endmodule

// ===== sv/pure_pursuit_steering.sv =====
// pure_pursuit_steering: top level; a pose beat runs through four 16-iteration cordic passes,
// rotation, vectoring, rotation and vectoring, with the lookahead scan between the first two;
// the scan reads one entry a cycle through a four-stage pipeline. the back end takes a new pose
// or load beat only when idle, after the last pose's result is in the output register; a load
// beat writes the tables, a four-entry queue decouples input. reset is synchronous
// active low: config registers take reset values, control clears, the tables are not cleared.
module pure_pursuit_steering
  import pps_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pps_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pps_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  logic [30:0]        lookahead_r, wheelbase_r;
  logic signed [15:0] speed_r;
  logic [10:0]        count_r;

  logic               q_valid, q_ready;
  pps_item_t          q_data;
  logic [QCW-1:0]     q_count;
  pps_cordic_req_t    creq;
  pps_cordic_sts_t    csts;
  logic signed [VW-1:0] c_x0, c_y0, c_x, c_y;
  logic signed [ZW-1:0] c_z0, c_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= 31'd65536;
      wheelbase_r <= 31'd19661;
      speed_r     <= 16'sd128;
      count_r     <= '0;
    end else if (cfg_we) begin
      case (pps_cfg_idx_t'(cfg_index))
        CFG_LOOKAHEAD: lookahead_r <= cfg_wdata;
        CFG_WHEELBASE: wheelbase_r <= cfg_wdata;
        CFG_SPEED:     speed_r     <= $signed(cfg_wdata[15:0]);
        CFG_COUNT:     count_r     <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  pps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .q_count  (q_count)
  );

  pps_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .x0    (c_x0),
    .y0    (c_y0),
    .z0    (c_z0),
    .sts   (csts),
    .x_out (c_x),
    .y_out (c_y),
    .z_out (c_z)
  );

  pps_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .lookahead (lookahead_r),
    .wheelbase (wheelbase_r),
    .speed     (speed_r),
    .wp_count  (count_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .creq      (creq),
    .c_x0      (c_x0),
    .c_y0      (c_y0),
    .c_z0      (c_z0),
    .csts      (csts),
    .c_x       (c_x),
    .c_y       (c_y),
    .c_z       (c_z)
  );

  // queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(QUEUE_DEPTH))
    else $error("queue fill level above depth");

  // a beat pushed without a pop grows the queue by one
  a_q_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(q_valid && q_ready)) |=> q_count == $past(q_count) + QCW'(1))
    else $error("queue fill level lost a pushed beat");

  // the sequencer never restarts the cordic mid pass
  a_cordic_start: assert property (@(posedge clk) disable iff (!rst_n)
    creq.start |-> !csts.busy)
    else $error("cordic started while busy");

endmodule

// ===== dv/pure_pursuit_steering_tb.sv =====
// pure_pursuit_steering_tb: self-checking bench for the pure pursuit steering block
// depends on pps_pkg and pure_pursuit_steering; predicts each steering beat in fixed point
module pure_pursuit_steering_tb
  import pps_pkg::*;
();

  localparam longint PI_FX      = 205887;
  localparam longint HALF_PI_FX = 102944;
  localparam longint TWO_PI_FX  = 411775;
  localparam longint GAIN_FX    = 652032875;
  localparam longint STEER_LIM  = 12868;
  localparam longint YAW_LIM    = 25736;
  localparam longint ARCTAN_FX [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pps_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pps_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_wdata = '0;

  pure_pursuit_steering dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // steering model state: registers and waypoint tables
  longint   la_m = 65536, wb_m = 19661, cnt_m = 0;
  logic [15:0] speed_m = 16'd128;
  longint   wx_m [1024];
  longint   wy_m [1024];

  // stimulus-side view of the tables, to keep every scan on written entries
  int       path_x [1024];
  int       path_y [1024];
  bit       written [1024];
  int       tb_count = 0;

  pps_in_t  pending_beats [$];
  pps_out_t steer_expected [$];
  int       mismatches = 0;
  int       poses_sent = 0, loads_sent = 0, steers_seen = 0;
  bit       idling_on = 1'b1;
  bit       hold_now = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("FAILED: results differ");
    $finish;
  end

  // cordic rotation: sin and cos (Q30) of a Q16 angle
  function automatic void rot_sincos(input longint ang, output longint sn, output longint cs);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_FX;
    y = 0;
    flip = 1'b0;
    ang = ang % TWO_PI_FX;
    if (ang > PI_FX) ang -= TWO_PI_FX;
    if (ang < -PI_FX) ang += TWO_PI_FX;
    if (ang > HALF_PI_FX) begin
      ang -= PI_FX;
      flip = 1'b1;
    end else if (ang < -HALF_PI_FX) begin
      ang += PI_FX;
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN_FX[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN_FX[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // cordic vectoring: atan2 as a Q16 angle
  function automatic longint vec_atan2(input longint y, input longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_FX : -PI_FX;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN_FX[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN_FX[i];
      end
      x = nx;
    end
    return z;
  endfunction

  // apply one accepted beat to the model, queue the steering result of a pose
  function automatic void apply_beat(input pps_in_t b);
    longint px, py, yq, sn, cs, xr, yr, dx, dy, ex, ey, ax, ay, d2, la_sq, num, z, st, n;
    int first, pick;
    pps_out_t r;
    px = longint'($signed(b.pos_x));
    py = longint'($signed(b.pos_y));
    if (b.cmd == CMD_LOAD) begin
      wx_m[b.waypoint_index] = px;
      wy_m[b.waypoint_index] = py;
      return;
    end
    yq = longint'($signed(b.yaw)) * 8;
    rot_sincos(yq, sn, cs);
    xr = px - ((cs * wb_m) >>> 31);
    yr = py - ((sn * wb_m) >>> 31);
    n = (cnt_m > 1024) ? 1024 : cnt_m;
    first = (b.closest_index > 0) ? int'(b.closest_index) - 1 : 0;
    la_sq = la_m * la_m;
    dx = 0;
    dy = 0;
    pick = 0;
    for (int i = first; i < n; i++) begin
      ex = wx_m[i] - xr;
      ey = wy_m[i] - yr;
      ax = (ex < 0) ? -ex : ex;
      ay = (ey < 0) ? -ey : ey;
      if (ax >= 64'sd2147483648 || ay >= 64'sd2147483648) d2 = 64'sh7FFF_FFFF_FFFF_FFFF;
      else d2 = ax * ax + ay * ay;
      if (d2 > la_sq || i == n - 1) begin
        dx = ex;
        dy = ey;
        pick = i;
        break;
      end
    end
    rot_sincos(vec_atan2(dy, dx) - yq, sn, cs);
    num = (sn * wb_m) >>> 29;
    z = vec_atan2(num, la_m);
    st = (z + 4) >>> 3;
    if (st > STEER_LIM) st = STEER_LIM;
    if (st < -STEER_LIM) st = -STEER_LIM;
    r.steer_cmd = st[14:0];
    r.speed_cmd = speed_m;
    r.lookahead_index = pick[9:0];
    steer_expected.push_back(r);
  endfunction

  // driver: offers queued beats, with bursts of idle cycles
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_beat(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
          if (idling_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks steering beats, stalls in bursts and once for a long stretch
  int stall_left = 0;
  always @(posedge clk) begin
    pps_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        steers_seen++;
        if (steer_expected.size() == 0) begin
          $error("unexpected steering beat %p", out_data);
          mismatches++;
        end else begin
          e = steer_expected.pop_front();
          if (out_data.steer_cmd !== e.steer_cmd) begin
            $error("steer_cmd expected %0d actual %0d", e.steer_cmd, out_data.steer_cmd);
            mismatches++;
          end
          if (out_data.speed_cmd !== e.speed_cmd) begin
            $error("speed_cmd expected %0d actual %0d", e.speed_cmd, out_data.speed_cmd);
            mismatches++;
          end
          if (out_data.lookahead_index !== e.lookahead_index) begin
            $error("lookahead_index expected %0d actual %0d",
                   e.lookahead_index, out_data.lookahead_index);
            mismatches++;
          end
        end
      end
      if (hold_now) begin
        hold_now = 1'b0;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_load(input int idx, input int x, input int y);
    pps_in_t b;
    b = '0;
    b.cmd = CMD_LOAD;
    b.waypoint_index = idx[9:0];
    b.pos_x = x;
    b.pos_y = y;
    b.yaw = 16'($urandom);
    b.closest_index = 10'($urandom);
    path_x[idx[9:0]] = x;
    path_y[idx[9:0]] = y;
    written[idx[9:0]] = 1'b1;
    pending_beats.push_back(b);
    loads_sent++;
  endfunction

  // lowest index from which every entry up to the count is written
  function automatic int scan_floor();
    int f;
    f = tb_count;
    while (f > 0 && written[f-1]) f--;
    return f;
  endfunction

  // closest index whose scan only touches written entries
  function automatic int safe_closest(input int c);
    int first, f;
    f = scan_floor();
    first = (c > 0) ? c - 1 : 0;
    if (first >= f || first >= tb_count) return c;
    return f + 1;
  endfunction

  function automatic void queue_pose(input int x, input int y, input int yaw, input int c);
    pps_in_t b;
    b = '0;
    b.cmd = CMD_POSE;
    b.waypoint_index = 10'($urandom);
    b.pos_x = x;
    b.pos_y = y;
    b.yaw = yaw[15:0];
    b.closest_index = 10'(safe_closest(c));
    pending_beats.push_back(b);
    poses_sent++;
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || steer_expected.size() > 0)
      @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic cfg_write(input pps_cfg_idx_t idx, input logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_LOOKAHEAD: la_m = longint'(v);
      CFG_WHEELBASE: wb_m = longint'(v);
      CFG_SPEED:     speed_m = v[15:0];
      CFG_COUNT:     begin
        cnt_m = longint'(v[10:0]);
        tb_count = (v[10:0] > 1024) ? 1024 : int'(v[10:0]);
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one settings phase: registers, a waypoint path, then a random mix of beats
  task automatic run_phase(input int cnt, input longint la, input longint wb,
                           input int spd, input int nbeats);
    int bx, by, step, lo, k, f, r, x, y;
    wait_idle();
    bx = $urandom_range(0, 1 << 25) - (1 << 24);
    by = $urandom_range(0, 1 << 25) - (1 << 24);
    step = $urandom_range(1 << 12, 1 << 18);
    if (la < 0) la = longint'(step) * $urandom_range(1, 6) + $urandom_range(0, step);
    if (wb < 0) wb = $urandom_range(0, 1 << 18);
    cfg_write(CFG_LOOKAHEAD, la[30:0]);
    cfg_write(CFG_WHEELBASE, wb[30:0]);
    cfg_write(CFG_SPEED, 31'(spd[15:0]));
    cfg_write(CFG_COUNT, 31'(cnt));
    lo = (cnt > 40) ? cnt - 24 : 0;
    for (int i = lo; i < cnt; i++)
      queue_load(i, bx + i * step, by + $urandom_range(0, step) - step / 2);
    for (int n = 0; n < nbeats; n++) begin
      r = $urandom_range(0, 99);
      f = scan_floor();
      if (r < 70 && tb_count > 0) begin
        // well-formed pose near the path
        k = $urandom_range(f, tb_count - 1);
        x = path_x[k] + $urandom_range(0, 4 * step) - 2 * step;
        y = path_y[k] + $urandom_range(0, 4 * step) - 2 * step;
        queue_pose(x, y, $urandom_range(0, 2 * YAW_LIM) - YAW_LIM,
                   (k + $urandom_range(0, 2) > 1023) ? 1023 : k + $urandom_range(0, 2));
      end else if (r < 85) begin
        k = $urandom_range(0, 1023);
        if ($urandom_range(0, 1)) queue_load(k, $urandom, $urandom);
        else queue_load(k, bx + k * step, by + $urandom_range(0, step));
      end else begin
        queue_pose($urandom, $urandom, $urandom_range(0, 65535), $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: waypoint count of zero with reset settings, extreme fields
    queue_load(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    queue_load(1023, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, YAW_LIM, 0);
    queue_pose(32'sh8000_0000, 32'sh8000_0000, -YAW_LIM, 1023);
    queue_pose(0, 0, 16'sh7FFF, 1);
    queue_pose(0, 0, -32768, 512);
    queue_pose(-1, -1, 0, 341);

    // count of one: only the last entry can be picked
    run_phase(1, 0, 0, -32768, 12);
    // far-apart extremes force saturated squared distances
    run_phase(2, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32767, 0);
    queue_pose(32'sh8000_0000, 32'sh8000_0000, 0, 0);
    queue_pose(32'sh7FFF_FFFF, 32'sh8000_0000, YAW_LIM, 1);
    queue_pose(0, 0, -YAW_LIM, 2);
    run_phase(16, -1, -1, 0, 60);
    run_phase(1024, -1, -1, $urandom_range(0, 65535) - 32768, 70);
    // receiver holds off while the sender keeps offering the previous phase's beats
    hold_now = 1'b1;
    run_phase($urandom_range(2, 60), -1, 31'h7FFF_FFFF, 256, 70);
    run_phase(1025 + $urandom_range(0, 1022), 31'h7FFF_FFFF, -1, 100, 60);
    run_phase($urandom_range(2, 60), -1, -1, $urandom_range(0, 65535) - 32768, 80);
    run_phase($urandom_range(2, 60), -1, -1, -1, 80);
    run_phase(0, -1, -1, 7, 20);
    wait_idle();
    idling_on = 1'b0;
    run_phase($urandom_range(2, 60), -1, -1, 128, 80);
    wait_idle();

    $display("covered %0d pose beats and %0d waypoint loads, %0d steering beats checked",
             poses_sent, loads_sent, steers_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pps_pkg.sv
sv/pps_front.sv
sv/pps_cordic.sv
sv/pps_back.sv
sv/pure_pursuit_steering.sv
dv/pure_pursuit_steering_tb.sv
